>>> design/crcfr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// crcfr_pkg
// Types, constants and the CRC-16 byte update shared by the frame receiver.
// ----------------------------------------------------------------------------
package crcfr_pkg;

    // Frame layout
    localparam int          PAYLOAD_BYTES = 7;
    localparam int          PAYLOAD_W     = 8 * PAYLOAD_BYTES;
    localparam logic [2:0]  MAX_PAYLOAD   = 3'd7;

    // CRC-16 generator, MSB first, zero seed, no final xor
    localparam logic [15:0] CRC_POLY      = 16'h1021;

    // Configuration register indexes
    localparam logic [0:0]  CFG_START_MARKER = 1'b0;
    localparam logic [0:0]  CFG_END_MARKER   = 1'b1;

    // Receiver phases
    typedef enum logic [2:0] {
        PH_HUNT  = 3'd0,
        PH_CTRL0 = 3'd1,
        PH_CTRL1 = 3'd2,
        PH_DATA  = 3'd3,
        PH_CRC0  = 3'd4,
        PH_CRC1  = 3'd5,
        PH_END   = 3'd6
    } phase_t;

    // One received word held in the input register
    typedef struct packed {
        logic       valid;
        logic [7:0] data;
    } byte_word_t;

    // One decoded frame
    typedef struct packed {
        logic [1:0]           frame_kind;
        logic [10:0]          seq_or_count;
        logic [2:0]           data_len;
        logic [PAYLOAD_W-1:0] payload;
        logic                 crc_ok;
        logic                 end_ok;
    } frame_t;

    // Shift one byte through the CRC register, one bit per step
    function automatic logic [15:0] crc_byte(input logic [15:0] acc, input logic [7:0] b);
        logic [15:0] r;
        r = acc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (r[15])
                r = {r[14:0], 1'b0} ^ CRC_POLY;
            else
                r = {r[14:0], 1'b0};
        end
        return r;
    endfunction

endpackage
`default_nettype wire

>>> design/crcfr_byte_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// crcfr_byte_if
// Valid/ready channel carrying one received serial byte per word.
// ----------------------------------------------------------------------------
interface crcfr_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface
`default_nettype wire

>>> design/crcfr_frame_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// crcfr_frame_if
// Valid/ready channel carrying one decoded frame per word.
// ----------------------------------------------------------------------------
interface crcfr_frame_if;
    logic        valid;
    logic        ready;
    logic [1:0]  frame_kind;
    logic [10:0] seq_or_count;
    logic [2:0]  data_len;
    logic [55:0] payload;
    logic        crc_ok;
    logic        end_ok;

    modport source (output valid, output frame_kind, output seq_or_count, output data_len,
                    output payload, output crc_ok, output end_ok, input ready);
    modport sink   (input valid, input frame_kind, input seq_or_count, input data_len,
                    input payload, input crc_ok, input end_ok, output ready);
endinterface
`default_nettype wire

>>> design/crc_checked_frame_receiver.sv
`default_nettype none
// ----------------------------------------------------------------------------
// crc_checked_frame_receiver
// Serial frame receiver: start marker, two control bytes, up to seven
// payload bytes, CRC-16 (0x1021, zero seed) and an end byte per frame.
// ----------------------------------------------------------------------------
//  channel  dir  handshake      word
//  rx       in   valid/ready    rx_byte, one received byte
//  frame    out  valid/ready    header fields, payload, crc_ok, end_ok
//  cfg      in   cfg_we         cfg_index selects start/end marker
//
//  A byte is taken every cycle unless the end byte is waiting for room in the
//  result register; each byte is registered, then parsed, and a frame result
//  lands in the result register on the cycle after the parser takes its end byte.
//  Reset clears both markers to zero and returns the parser to hunting.
//  A stalled frame word holds the end byte in the input register, and the
//  bytes behind it wait until the result register has room.
// ----------------------------------------------------------------------------
module crc_checked_frame_receiver (
    input  wire logic        clk,
    input  wire logic        rst_n,
    crcfr_byte_if.sink       rx,
    crcfr_frame_if.source    frame,
    input  wire logic        cfg_we,
    input  wire logic [0:0]  cfg_index,
    input  wire logic [7:0]  cfg_data
);

    logic [7:0]             start_marker_reg;
    logic [7:0]             end_marker_reg;
    crcfr_pkg::byte_word_t  word;
    crcfr_pkg::frame_t      result;
    logic                   take;
    logic                   load;
    logic                   out_free;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_marker_reg <= '0;
            end_marker_reg   <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                crcfr_pkg::CFG_START_MARKER: start_marker_reg <= cfg_data;
                crcfr_pkg::CFG_END_MARKER:   end_marker_reg   <= cfg_data;
                default:                     ;
            endcase
        end
    end

    crcfr_in_stage u_in_stage (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx),
        .take  (take),
        .word  (word)
    );

    crcfr_deframer u_deframer (
        .clk          (clk),
        .rst_n        (rst_n),
        .word         (word),
        .out_free     (out_free),
        .start_marker (start_marker_reg),
        .end_marker   (end_marker_reg),
        .take         (take),
        .load         (load),
        .result       (result)
    );

    crcfr_out_stage u_out_stage (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (load),
        .result (result),
        .free   (out_free),
        .frame  (frame)
    );

endmodule
`default_nettype wire

>>> design/crcfr_in_stage.sv
`default_nettype none
// ----------------------------------------------------------------------------
// crcfr_in_stage
// Input register: captures one received byte and holds it until the
// deframer consumes it; refills in the same cycle it is consumed.
// ----------------------------------------------------------------------------
module crcfr_in_stage (
    input  wire logic              clk,
    input  wire logic              rst_n,
    crcfr_byte_if.sink             rx,
    input  wire logic              take,
    output crcfr_pkg::byte_word_t  word
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] data_reg;
    logic       load;

    // Accept when empty or when the held word leaves this cycle
    assign rx.ready = !valid_reg || take;
    assign load     = rx.valid && rx.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
            valid_next = 1'b1;
        else if (take)
            valid_next = 1'b0;
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // Capture payload
    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= rx.rx_byte;
    end

    assign word.valid = valid_reg;
    assign word.data  = data_reg;

endmodule
`default_nettype wire

>>> design/crcfr_deframer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// crcfr_deframer
// Frame parser: walks the frame phases one byte at a time, collects the
// header and payload, runs the CRC and builds the result on the end byte.
// ----------------------------------------------------------------------------
module crcfr_deframer (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire crcfr_pkg::byte_word_t word,
    input  wire logic              out_free,
    input  wire logic [7:0]        start_marker,
    input  wire logic [7:0]        end_marker,
    output logic                   take,
    output logic                   load,
    output crcfr_pkg::frame_t      result
);

    crcfr_pkg::phase_t                phase_reg;
    crcfr_pkg::phase_t                phase_next;
    logic [1:0]                       kind_reg;
    logic [1:0]                       kind_next;
    logic [10:0]                      seq_reg;
    logic [10:0]                      seq_next;
    logic [2:0]                       len_reg;
    logic [2:0]                       len_next;
    logic [2:0]                       byte_index_reg;
    logic [2:0]                       byte_index_next;
    logic [crcfr_pkg::PAYLOAD_W-1:0]  payload_reg;
    logic [crcfr_pkg::PAYLOAD_W-1:0]  payload_next;
    logic [15:0]                      crc_reg;
    logic [15:0]                      crc_next;
    logic [2:0]                       len_sat;
    logic [2:0]                       index_inc;
    logic [15:0]                      crc_upd;
    logic [7:0]                       b;

    assign b = word.data;

    // Consume the held byte; the end byte waits for room in the result register
    assign take = word.valid && ((phase_reg != crcfr_pkg::PH_END) || out_free);
    assign load = word.valid && (phase_reg == crcfr_pkg::PH_END) && out_free;

    // Saturate the length field
    always_comb
    begin
        len_sat = b[2:0];
        if (len_sat > crcfr_pkg::MAX_PAYLOAD)
            len_sat = crcfr_pkg::MAX_PAYLOAD;
    end

    assign index_inc = byte_index_reg + 3'd1;
    assign crc_upd   = crcfr_pkg::crc_byte(crc_reg, b);

    // Next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (take)
        begin
            unique case (phase_reg)
                crcfr_pkg::PH_HUNT:
                    if (b == start_marker)
                        phase_next = crcfr_pkg::PH_CTRL0;
                crcfr_pkg::PH_CTRL0:
                    phase_next = crcfr_pkg::PH_CTRL1;
                crcfr_pkg::PH_CTRL1:
                    phase_next = (len_sat == 3'd0) ? crcfr_pkg::PH_CRC0 : crcfr_pkg::PH_DATA;
                crcfr_pkg::PH_DATA:
                    if (index_inc >= len_reg)
                        phase_next = crcfr_pkg::PH_CRC0;
                crcfr_pkg::PH_CRC0:
                    phase_next = crcfr_pkg::PH_CRC1;
                crcfr_pkg::PH_CRC1:
                    phase_next = crcfr_pkg::PH_END;
                default:
                    phase_next = crcfr_pkg::PH_HUNT;
            endcase
        end
    end

    // Datapath updates per phase
    always_comb
    begin
        kind_next       = kind_reg;
        seq_next        = seq_reg;
        len_next        = len_reg;
        byte_index_next = byte_index_reg;
        payload_next    = payload_reg;
        crc_next        = crc_reg;
        if (take)
        begin
            unique case (phase_reg)
                crcfr_pkg::PH_CTRL0:
                begin
                    kind_next       = b[7:6];
                    seq_next        = {b[5:0], 5'd0};
                    payload_next    = '0;
                    crc_next        = '0;
                    byte_index_next = 3'd0;
                end
                crcfr_pkg::PH_CTRL1:
                begin
                    seq_next        = {seq_reg[10:5], b[7:3]};
                    len_next        = len_sat;
                    byte_index_next = 3'd0;
                end
                crcfr_pkg::PH_DATA:
                begin
                    for (int i = 0; i < crcfr_pkg::PAYLOAD_BYTES; i++) begin
                        if (byte_index_reg == 3'(i))
                            payload_next[8*i +: 8] = payload_reg[8*i +: 8] | b;
                    end
                    crc_next        = crc_upd;
                    byte_index_next = index_inc;
                end
                crcfr_pkg::PH_CRC0, crcfr_pkg::PH_CRC1:
                    crc_next = crc_upd;
                default:
                    ;
            endcase
        end
    end

    // Build the result on the end byte
    always_comb
    begin
        result.frame_kind   = kind_reg;
        result.seq_or_count = seq_reg;
        result.data_len     = len_reg;
        result.payload      = payload_reg;
        result.crc_ok       = (crc_reg == 16'd0);
        result.end_ok       = (b == end_marker);
    end

    // Advance state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= crcfr_pkg::PH_HUNT;
            kind_reg       <= '0;
            seq_reg        <= '0;
            len_reg        <= '0;
            byte_index_reg <= '0;
            payload_reg    <= '0;
            crc_reg        <= '0;
        end
        else
        begin
            phase_reg      <= phase_next;
            kind_reg       <= kind_next;
            seq_reg        <= seq_next;
            len_reg        <= len_next;
            byte_index_reg <= byte_index_next;
            payload_reg    <= payload_next;
            crc_reg        <= crc_next;
        end
    end

endmodule
`default_nettype wire

>>> design/crcfr_out_stage.sv
`default_nettype none
// ----------------------------------------------------------------------------
// crcfr_out_stage
// Result register: holds one decoded frame until the sink takes it.
// ----------------------------------------------------------------------------
module crcfr_out_stage (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          load,
    input  wire crcfr_pkg::frame_t result,
    output logic               free,
    crcfr_frame_if.source      frame
);

    logic               valid_reg;
    logic               valid_next;
    crcfr_pkg::frame_t  data_reg;

    // Room when empty or when the held word leaves this cycle
    assign free = !valid_reg || frame.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
            valid_next = 1'b1;
        else if (frame.ready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // Capture payload
    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= result;
    end

    assign frame.valid        = valid_reg;
    assign frame.frame_kind   = data_reg.frame_kind;
    assign frame.seq_or_count = data_reg.seq_or_count;
    assign frame.data_len     = data_reg.data_len;
    assign frame.payload      = data_reg.payload;
    assign frame.crc_ok       = data_reg.crc_ok;
    assign frame.end_ok       = data_reg.end_ok;

endmodule
`default_nettype wire

>>> tb/sv/crc_checked_frame_receiver_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// crc_checked_frame_receiver_tb
// Feeds byte streams to the frame receiver: framed words with good and bad
// CRC, right and wrong closing bytes, noise and cut-off frames, under several
// start/end marker settings. A local frame decoder tracks the parser and
// queues the frame each closing byte should produce; every frame word leaving
// the block is checked field by field against the head of that queue.
// ----------------------------------------------------------------------------
module crc_checked_frame_receiver_tb;

    localparam int WATCHDOG_CYCLES          = 5000;
    localparam int HOLD_CYCLES              = 300;
    localparam int SETTLE_CYCLES            = 4;
    localparam int RANDOM_SETTINGS          = 6;
    localparam int RANDOM_BYTES_PER_SETTING = 180;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       cfg_we;
    logic [0:0] cfg_index;
    logic [7:0] cfg_data;

    crcfr_byte_if  rx_ch ();
    crcfr_frame_if frame_ch ();

    crc_checked_frame_receiver dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .rx        (rx_ch),
        .frame     (frame_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 100 MHz clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Marker copies and decoder state, as the block should hold them
    logic [7:0]                      start_mk = 8'h00;
    logic [7:0]                      end_mk   = 8'h00;
    crcfr_pkg::phase_t               rx_phase = crcfr_pkg::PH_HUNT;
    logic [1:0]                      kind_acc;
    logic [10:0]                     seq_acc;
    logic [2:0]                      len_acc;
    logic [2:0]                      byte_idx;
    logic [crcfr_pkg::PAYLOAD_W-1:0] payload_acc;
    logic [15:0]                     crc_acc;

    crcfr_pkg::frame_t frame_q[$];

    // Traffic shaping shared with the frame sink
    bit gaps_on     = 1'b1;
    bit sink_stalls = 1'b1;
    bit hold_req    = 1'b0;

    int bytes_sent     = 0;
    int frames_checked = 0;
    int reg_writes     = 0;
    int mismatches     = 0;

    // Advance a CRC-16/0x1021 register by one byte, one input bit at a time
    function automatic logic [15:0] crc16_step(input logic [15:0] acc, input logic [7:0] b);
        logic [15:0] r;
        logic        fb;
        r = acc;
        for (int i = 7; i >= 0; i--)
        begin
            fb = r[15] ^ b[i];
            r  = {r[14:0], 1'b0};
            if (fb)
                r = r ^ crcfr_pkg::CRC_POLY;
        end
        return r;
    endfunction

    // Advance the frame decoder by one accepted byte; queue a frame on the closing byte
    function automatic void decode_byte(input logic [7:0] b);
        crcfr_pkg::frame_t f;
        case (rx_phase)
            crcfr_pkg::PH_HUNT:
            begin
                if (b == start_mk)
                    rx_phase = crcfr_pkg::PH_CTRL0;
            end
            crcfr_pkg::PH_CTRL0:
            begin
                kind_acc    = b[7:6];
                seq_acc     = {b[5:0], 5'd0};
                payload_acc = '0;
                crc_acc     = 16'h0000;
                byte_idx    = 3'd0;
                rx_phase    = crcfr_pkg::PH_CTRL1;
            end
            crcfr_pkg::PH_CTRL1:
            begin
                seq_acc[4:0] = b[7:3];
                len_acc      = (b[2:0] > crcfr_pkg::MAX_PAYLOAD) ? crcfr_pkg::MAX_PAYLOAD
                                                                 : b[2:0];
                byte_idx     = 3'd0;
                rx_phase     = (len_acc == 3'd0) ? crcfr_pkg::PH_CRC0 : crcfr_pkg::PH_DATA;
            end
            crcfr_pkg::PH_DATA:
            begin
                payload_acc[{byte_idx, 3'b000} +: 8] = b;
                crc_acc  = crc16_step(crc_acc, b);
                byte_idx = byte_idx + 3'd1;
                if (byte_idx >= len_acc)
                    rx_phase = crcfr_pkg::PH_CRC0;
            end
            crcfr_pkg::PH_CRC0:
            begin
                crc_acc  = crc16_step(crc_acc, b);
                rx_phase = crcfr_pkg::PH_CRC1;
            end
            crcfr_pkg::PH_CRC1:
            begin
                crc_acc  = crc16_step(crc_acc, b);
                rx_phase = crcfr_pkg::PH_END;
            end
            crcfr_pkg::PH_END:
            begin
                f.frame_kind   = kind_acc;
                f.seq_or_count = seq_acc;
                f.data_len     = len_acc;
                f.payload      = payload_acc;
                f.crc_ok       = (crc_acc == 16'h0000);
                f.end_ok       = (b == end_mk);
                frame_q.push_back(f);
                rx_phase       = crcfr_pkg::PH_HUNT;
            end
            default:
                rx_phase = crcfr_pkg::PH_HUNT;
        endcase
    endfunction

    // Idle length: mostly none, some short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 88)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 15);
        else
            return $urandom_range(20, 60);
    endfunction

    // Offer one byte, hold it until accepted, then maybe idle
    task automatic send_byte(input logic [7:0] b);
        int gap;
        rx_ch.valid   <= 1'b1;
        rx_ch.rx_byte <= b;
        @(posedge clk);
        while (!rx_ch.ready)
            @(posedge clk);
        decode_byte(b);
        bytes_sent++;
        if (gaps_on)
        begin
            gap = pick_gap();
            if (gap > 0)
            begin
                rx_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // Stop offering and wait until every queued frame has come out
    task automatic drain();
        rx_ch.valid <= 1'b0;
        while (frame_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write a marker register once every queued frame has come out
    task automatic write_reg(input logic [0:0] idx, input logic [7:0] value);
        drain();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == crcfr_pkg::CFG_START_MARKER)
            start_mk = value;
        else
            end_mk = value;
        reg_writes++;
    endtask

    // Send one whole frame; the CRC is appended so the remainder is zero unless corrupted
    task automatic send_full_frame(input logic [1:0] kind, input logic [10:0] seq,
                                   input logic [2:0] len,
                                   input logic [crcfr_pkg::PAYLOAD_W-1:0] data,
                                   input bit bad_crc, input logic [7:0] closing);
        logic [15:0] crc;
        int          flip;
        crc = 16'h0000;
        send_byte(start_mk);
        send_byte({kind, seq[10:5]});
        send_byte({seq[4:0], len});
        for (int i = 0; i < len; i++)
        begin
            send_byte(data[8*i +: 8]);
            crc = crc16_step(crc, data[8*i +: 8]);
        end
        if (bad_crc)
        begin
            flip      = $urandom_range(0, 15);
            crc[flip] = ~crc[flip];
        end
        send_byte(crc[15:8]);
        send_byte(crc[7:0]);
        send_byte(closing);
    endtask

    // Random frame; optionally with payload bytes drawn from the marker values
    task automatic send_random_frame(input bit marker_laden);
        logic [crcfr_pkg::PAYLOAD_W-1:0] data;
        logic [7:0]                      closing;
        int                              pick;
        for (int i = 0; i < crcfr_pkg::PAYLOAD_BYTES; i++)
        begin
            pick = $urandom_range(0, 2);
            if (!marker_laden || pick == 2)
                data[8*i +: 8] = 8'($urandom);
            else
                data[8*i +: 8] = (pick == 0) ? start_mk : end_mk;
        end
        closing = ($urandom_range(0, 4) == 0) ? 8'($urandom) : end_mk;
        send_full_frame(2'($urandom), 11'($urandom), 3'($urandom), data,
                        $urandom_range(0, 6) == 0, closing);
    endtask

    // Line noise that never opens a frame
    task automatic send_noise(input int count);
        logic [7:0] b;
        repeat (count)
        begin
            b = 8'($urandom);
            if (b == start_mk)
                b = ~b;
            send_byte(b);
        end
    endtask

    // Start marker followed by a few random bytes, which can cut the frame off before it ends
    task automatic send_truncated();
        send_byte(start_mk);
        repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
    endtask

    // Markers at reset value: header and payload extremes, bad CRC, wrong closer
    task automatic test_reset_markers();
        send_full_frame(2'd3, 11'd2047, 3'd0, '0, 1'b0, 8'h00);
        send_full_frame(2'd0, 11'd0, 3'd7, 56'hFF_7F_00_01_80_FF_00, 1'b1, 8'hA5);
        send_byte(8'h01);
        send_byte(8'hFE);
    endtask

    // Marker extremes, swapped between start and end
    task automatic test_marker_extremes();
        write_reg(crcfr_pkg::CFG_START_MARKER, 8'hFF);
        write_reg(crcfr_pkg::CFG_END_MARKER, 8'h00);
        repeat (6) send_random_frame($urandom_range(0, 1));
        write_reg(crcfr_pkg::CFG_START_MARKER, 8'h00);
        write_reg(crcfr_pkg::CFG_END_MARKER, 8'hFF);
        repeat (6) send_random_frame($urandom_range(0, 1));
    endtask

    // Change markers while a frame is half received
    task automatic test_midframe_write();
        logic [7:0] new_end;
        write_reg(crcfr_pkg::CFG_START_MARKER, 8'h3C);
        send_byte(start_mk);
        write_reg(crcfr_pkg::CFG_START_MARKER, 8'hC3);
        send_byte(8'h95);
        send_byte(8'h28);
        send_byte(8'h00);
        send_byte(8'h00);
        new_end = 8'($urandom);
        write_reg(crcfr_pkg::CFG_END_MARKER, new_end);
        send_byte(new_end);
        send_random_frame(1'b0);
    endtask

    // Mixed traffic across several random marker settings
    task automatic test_random_traffic();
        int base;
        int pick;
        for (int s = 0; s < RANDOM_SETTINGS; s++)
        begin
            write_reg(crcfr_pkg::CFG_START_MARKER, 8'($urandom));
            write_reg(crcfr_pkg::CFG_END_MARKER, (s == 0) ? start_mk : 8'($urandom));
            sink_stalls = (s != 2);
            base = bytes_sent;
            while (bytes_sent - base < RANDOM_BYTES_PER_SETTING)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 72)
                    send_random_frame(1'b0);
                else if (pick < 84)
                    send_random_frame(1'b1);
                else if (pick < 93)
                    send_noise($urandom_range(1, 5));
                else
                    send_truncated();
            end
        end
        sink_stalls = 1'b1;
    endtask

    // Hold the frame sink off while frames keep arriving back to back
    task automatic test_backpressure();
        gaps_on  = 1'b0;
        hold_req = 1'b1;
        repeat (5) send_random_frame(1'b0);
        drain();
        gaps_on = 1'b1;
    endtask

    // Both sides at full rate, no idling at all
    task automatic test_full_rate();
        gaps_on     = 1'b0;
        sink_stalls = 1'b0;
        repeat (10) send_random_frame($urandom_range(0, 1));
        drain();
        gaps_on     = 1'b1;
        sink_stalls = 1'b1;
    endtask

    // Frame sink: random stalls, or one long hold when asked
    initial
    begin : frame_sink
        int stall;
        int held;
        frame_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                frame_ch.ready <= 1'b0;
                held = 0;
                while (held < HOLD_CYCLES)
                begin
                    @(posedge clk);
                    held++;
                end
                hold_req = 1'b0;
            end
            else
            begin
                stall = sink_stalls ? pick_gap() : 0;
                if (stall == 0)
                    frame_ch.ready <= 1'b1;
                else
                begin
                    frame_ch.ready <= 1'b0;
                    repeat (stall) @(posedge clk);
                end
            end
        end
    end

    // Check each accepted frame word against the oldest queued frame
    always @(posedge clk)
    begin : frame_check
        crcfr_pkg::frame_t want;
        if (rst_n && frame_ch.valid && frame_ch.ready)
        begin
            if (frame_q.size() == 0)
            begin
                $error("frame word with no frame expected");
                mismatches++;
            end
            else
            begin
                want = frame_q.pop_front();
                frames_checked++;
                if (frame_ch.frame_kind !== want.frame_kind)
                begin
                    $error("frame_kind: expected %0d, actual %0d",
                           want.frame_kind, frame_ch.frame_kind);
                    mismatches++;
                end
                if (frame_ch.seq_or_count !== want.seq_or_count)
                begin
                    $error("seq_or_count: expected %0d, actual %0d",
                           want.seq_or_count, frame_ch.seq_or_count);
                    mismatches++;
                end
                if (frame_ch.data_len !== want.data_len)
                begin
                    $error("data_len: expected %0d, actual %0d",
                           want.data_len, frame_ch.data_len);
                    mismatches++;
                end
                if (frame_ch.payload !== want.payload)
                begin
                    $error("payload: expected %h, actual %h",
                           want.payload, frame_ch.payload);
                    mismatches++;
                end
                if (frame_ch.crc_ok !== want.crc_ok)
                begin
                    $error("crc_ok: expected %0d, actual %0d",
                           want.crc_ok, frame_ch.crc_ok);
                    mismatches++;
                end
                if (frame_ch.end_ok !== want.end_ok)
                begin
                    $error("end_ok: expected %0d, actual %0d",
                           want.end_ok, frame_ch.end_ok);
                    mismatches++;
                end
            end
        end
    end

    // End the run if neither channel moves a word for too long
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_CYCLES)
        begin
            @(posedge clk);
            if (rst_n && ((rx_ch.valid && rx_ch.ready) || (frame_ch.valid && frame_ch.ready)))
                quiet = 0;
            else
                quiet++;
        end
        $display("watchdog: no traffic for %0d cycles, %0d frames still due",
                 WATCHDOG_CYCLES, frame_q.size());
        $display("Simulation FAILED");
        $finish;
    end

    // Reset, then run each test in turn
    initial
    begin
        rst_n         <= 1'b0;
        rx_ch.valid   <= 1'b0;
        rx_ch.rx_byte <= 8'h00;
        cfg_we        <= 1'b0;
        cfg_index     <= crcfr_pkg::CFG_START_MARKER;
        cfg_data      <= 8'h00;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_markers();
        test_marker_extremes();
        test_midframe_write();
        test_backpressure();
        test_random_traffic();
        test_full_rate();
        drain();

        $display("Sent %0d bytes, checked %0d frames over %0d marker writes,",
                 bytes_sent, frames_checked, reg_writes);
        $display("with noise, cut-off frames, bad CRCs, mid-frame writes and sink hold-off.");
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
